>>> rtl/bdd_pkg.sv
// Shared constants, types and register codes for the battery disconnect detector.
// No dependencies; every rtl file imports this package.
package bdd_pkg;

	localparam int DEPTH      = 1024;
	localparam int DEPTH_LOG2 = 10;
	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = SAMPLE_W + DEPTH_LOG2;
	localparam int GAIN_W     = 8;
	localparam int SHIFT_W    = 4;
	localparam int PROD_W     = GAIN_W + SAMPLE_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(1);
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(1);

	typedef logic [DEPTH_LOG2-1:0] addr_t;
	typedef logic [SAMPLE_W-1:0]   sample_t;
	typedef logic [SUM_W-1:0]      sum_t;
	typedef logic [PROD_W-1:0]     prod_t;

	localparam addr_t LAST_ADDR = addr_t'(DEPTH - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN  = 2'd0,
		REG_SHIFT = 2'd1
	} cfg_reg_t;

	// pipeline control: adv moves every stage, take loads a new word
	typedef struct packed {
		logic adv;
		logic take;
	} pipe_ctl_t;

endpackage

>>> rtl/bdd_window.sv
// Sample window: circular sample memory, write pointer and running sum.
// Produces the moving average per word. Depends on bdd_pkg.
module bdd_window
	import bdd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pipe_ctl_t ctl,
	input  sample_t   voltage_sample,
	output logic      valid_s2,
	output sample_t   avg_s2,
	output sample_t   sample_s2
);

	sample_t mem [DEPTH];
	sample_t rdata_q;

	addr_t   wp_q;
	logic    wrapped_q;
	sum_t    sum_q;

	logic    valid_s1;
	sample_t sample_s1;
	addr_t   wp_s1;
	logic    old_ok_s1;

	sample_t old_sample;
	sum_t    sum_next;

	// read the oldest entry at accept, write the new word back as it leaves stage 1;
	// consecutive words always touch different entries
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			rdata_q <= mem[wp_q];
		end
		if (ctl.adv && valid_s1) begin
			mem[wp_s1] <= sample_s1;
		end
	end

	// entries are written in pointer order, so an entry holds data only
	// after the pointer has wrapped once; before that it reads as zero
	assign old_sample = old_ok_s1 ? rdata_q : '0;
	assign sum_next   = sum_q - sum_t'(old_sample) + sum_t'(sample_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
		end else begin
			if (ctl.take) begin
				if (wp_q == LAST_ADDR) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + addr_t'(1);
				end
			end
			if (ctl.adv) begin
				valid_s1 <= ctl.take;
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					sum_q <= sum_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			sample_s1 <= voltage_sample;
			wp_s1     <= wp_q;
			old_ok_s1 <= wrapped_q;
		end
		if (ctl.adv && valid_s1) begin
			sample_s2 <= sample_s1;
			avg_s2    <= sum_next[DEPTH_LOG2 +: SAMPLE_W];
		end
	end

endmodule

>>> rtl/bdd_thresh.sv
// Threshold stage: gain multiply, shift, compare and output register.
// Depends on bdd_pkg.
module bdd_thresh
	import bdd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  pipe_ctl_t          ctl,
	input  logic               valid_s2,
	input  sample_t            avg_s2,
	input  sample_t            sample_s2,
	input  logic [GAIN_W-1:0]  gain,
	input  logic [SHIFT_W-1:0] shift,
	output logic               result_valid,
	output logic               disconnected
);

	logic    valid_s3;
	prod_t   prod_s3;
	sample_t sample_s3;
	sample_t threshold;

	assign threshold = sample_t'(prod_s3 >> shift);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3     <= 1'b0;
			result_valid <= 1'b0;
		end else if (ctl.adv) begin
			valid_s3     <= valid_s2;
			result_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && valid_s2) begin
			prod_s3   <= prod_t'(gain) * prod_t'(avg_s2);
			sample_s3 <= sample_s2;
		end
		if (ctl.adv && valid_s3) begin
			disconnected <= (sample_s3 < threshold);
		end
	end

endmodule

>>> rtl/battery_disconnect_detector_core.sv
// Battery disconnect detector: one voltage word per cycle, sustained unless the
// result side stalls. Each word replaces the oldest of 1024 samples held in a
// simple dual-port memory (read at accept, written back as the word leaves
// stage 1), a running sum gives the moving average, and the flag is set when the
// sample is below the low 16 bits of (gain * average) >> shift. result_valid
// rises once its sample has passed four register stages; a stall on the result
// side holds the whole pipeline. No clearing pass after reset: entries not yet
// written read as zero, so early averages run low. Config writes are taken at any
// time (cfg_ready is always high) but must only be made while the block is idle.
// Depends on bdd_pkg, bdd_window and bdd_thresh.
module battery_disconnect_detector_core
	import bdd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  sample_t               voltage_sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  disconnected,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	pipe_ctl_t          ctl;
	logic [GAIN_W-1:0]  gain_q;
	logic [SHIFT_W-1:0] shift_q;

	logic    valid_s2;
	sample_t avg_s2;
	sample_t sample_s2;

	assign ctl.adv      = !(result_valid && result_stall);
	assign ctl.take     = !(result_valid && result_stall) && sample_valid;
	assign sample_stall = result_valid && result_stall;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RESET;
			shift_q <= SHIFT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN:  gain_q  <= cfg_data[GAIN_W-1:0];
				REG_SHIFT: shift_q <= cfg_data[SHIFT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bdd_window u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.voltage_sample (voltage_sample),
		.valid_s2       (valid_s2),
		.avg_s2         (avg_s2),
		.sample_s2      (sample_s2)
	);

	bdd_thresh u_thresh (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.valid_s2     (valid_s2),
		.avg_s2       (avg_s2),
		.sample_s2    (sample_s2),
		.gain         (gain_q),
		.shift        (shift_q),
		.result_valid (result_valid),
		.disconnected (disconnected)
	);

endmodule

>>> tb/battery_disconnect_detector_core_test.sv
// Self-checking testbench for battery_disconnect_detector_core: tracks the 1024-entry
// moving average and gain/shift threshold in the bench and checks every flag in order.
// Depends on bdd_pkg and the detector rtl; random stalls and gaps on both streams.
module battery_disconnect_detector_core_test;
	import bdd_pkg::*;

	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_GAP        = 16;
	localparam int REPORT_LIMIT   = 10;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 2'd3;

	typedef struct {
		int      idx;
		sample_t word;
		logic    flag;
	} flag_expect_t;

	logic                  clk;
	logic                  arst_n;
	logic                  sample_valid;
	logic                  sample_stall;
	sample_t               voltage_sample;
	logic                  result_valid;
	logic                  result_stall;
	logic                  disconnected;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// bench copy of the detector state
	sample_t            win_store [DEPTH];
	sum_t               win_sum;
	addr_t              win_ptr;
	logic [GAIN_W-1:0]  gain;
	logic [SHIFT_W-1:0] shift;

	flag_expect_t pending_flags [$];
	int  errors;
	int  n_samples;
	int  n_flagged;
	int  n_cfg_writes;
	int  stall_left;
	int  idle_cycles;
	bit  idle_en;

	battery_disconnect_detector_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.voltage_sample (voltage_sample),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.disconnected   (disconnected),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic sample_t threshold_of(sum_t s);
		prod_t p;
		p = prod_t'(gain) * prod_t'(sample_t'(s >> DEPTH_LOG2));
		return sample_t'(p >> shift);
	endfunction

	// window update and flag for one accepted word
	function automatic logic disconnect_flag(sample_t word);
		win_sum = win_sum - sum_t'(win_store[win_ptr]) + sum_t'(word);
		win_store[win_ptr] = word;
		win_ptr = win_ptr + addr_t'(1);
		return word < threshold_of(win_sum);
	endfunction

	// result side: check each accepted word against the oldest expectation
	always @(posedge clk) begin
		flag_expect_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_flags.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result word: disconnected=%0b", disconnected);
			end else begin
				e = pending_flags.pop_front();
				if (disconnected !== e.flag) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("mismatch on word %0d (sample 0x%04h): expected %0b got %0b",
							e.idx, e.word, e.flag, disconnected);
				end
			end
			stall_left = idle_en ? $urandom_range(0, MAX_GAP) : 0;
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", idle_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// entered and left at a falling edge; valid stays high between back-to-back words
	task automatic send_sample(input sample_t word);
		int gap;
		gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid   <= 1'b1;
		voltage_sample <= word;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		pending_flags.push_back('{n_samples, word, disconnect_flag(word)});
		if (pending_flags[$].flag) n_flagged++;
		n_samples++;
		@(negedge clk);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (pending_flags.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_GAIN:  gain  = data;
			REG_SHIFT: shift = data[SHIFT_W-1:0];
			default:   ;
		endcase
		n_cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [GAIN_W-1:0] g, input logic [SHIFT_W-1:0] s);
		drain();
		write_reg(REG_GAIN, g);
		write_reg(REG_SHIFT, CFG_DATA_W'(s));
	endtask

	// zeroed store after reset: early averages run low
	task automatic test_startup();
		set_config(GAIN_RESET, SHIFT_RESET);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		send_sample(16'h0001);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h0000);
		send_sample(16'h0040);
		send_sample(16'hFFFF);
	endtask

	// spare indices are ignored, upper shift bits dropped
	task automatic test_register_bits();
		drain();
		write_reg(IDX_SPARE_A, 8'hFF);
		write_reg(IDX_SPARE_B, 8'h00);
		write_reg(REG_SHIFT, 8'hF3);
		write_reg(REG_GAIN, 8'h0A);
		send_sample(16'h0000);
		send_sample(16'h1234);
		send_sample(16'hFFFF);
		send_sample(16'h0100);
	endtask

	// gain/shift extremes, incl. threshold wider than 16 bits
	task automatic test_gain_extremes();
		set_config(8'd255, 4'd0);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		send_sample(16'h8000);
		send_sample(16'h00FF);
		set_config(8'd0, 4'd15);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h0001);
	endtask

	// long stream passes the pointer wrap; most words land near the threshold
	task automatic test_random_stream();
		int t;
		int pick;
		logic [GAIN_W-1:0] g;
		logic [SHIFT_W-1:0] s;
		for (int ph = 0; ph < 8; ph++) begin
			g = (ph == 1 || ph == 5) ? 8'd255 : (ph == 2) ? 8'd0 : 8'($urandom_range(1, 255));
			s = (ph == 1) ? 4'd0 : (ph == 3) ? 4'd15 : (ph == 6) ? 4'd1 :
				4'($urandom_range(0, 15));
			if (ph == 6) g = 8'd1;
			set_config(g, s);
			idle_en = (ph != 4);
			for (int i = 0; i < 200; i++) begin
				if (ph == 2 && i == 100)
					drain();
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					t = int'(threshold_of(win_sum)) + $urandom_range(0, 64) - 32;
					if (t < 0) t = 0;
					if (t > 16'hFFFF) t = 16'hFFFF;
				end else if (pick < 85) begin
					t = $urandom_range(0, 16'hFFFF);
				end else if (pick < 93) begin
					t = 16'hFFFF;
				end else begin
					t = 0;
				end
				send_sample(sample_t'(t));
			end
		end
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		sample_valid   = 1'b0;
		voltage_sample = '0;
		result_stall   = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		for (int i = 0; i < DEPTH; i++) win_store[i] = '0;
		win_sum      = '0;
		win_ptr      = '0;
		gain         = GAIN_RESET;
		shift        = SHIFT_RESET;
		errors       = 0;
		n_samples    = 0;
		n_flagged    = 0;
		n_cfg_writes = 0;
		stall_left   = 0;
		idle_cycles  = 0;
		idle_en      = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_startup();
		test_register_bits();
		test_gain_extremes();
		test_random_stream();
		drain();

		$display("%0d samples checked (%0d flagged disconnected), %0d register writes,",
			n_samples, n_flagged, n_cfg_writes);
		$display("window wrapped, gain 0..255 and shift 0..15 exercised; %0d errors", errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
